// ===== rtl/core/bmrsc_pkg.sv =====
// Package with shared constants, request codes and control types for the bitmap range block.
`timescale 1ns / 1ps
package bmrsc_pkg;

	// Map geometry.
	localparam int unsigned MAP_BITS  = 4096;
	localparam int unsigned MAP_BYTES = (MAP_BITS + 7) / 8;
	localparam int unsigned ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

	// Field widths of one transaction.
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned DATA_W  = 8;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_SET   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// Byte constants.
	localparam logic [DATA_W-1:0] BYTE_ONES  = 8'hFF;
	localparam logic [DATA_W-1:0] BYTE_ZEROS = 8'h00;
	localparam logic [2:0]        BIT_TOP    = 3'd7;

	// Controller states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd_en;
		logic wr_part;
		logic wr_full;
		logic step;
		logic clr_wr;
		logic take_rd;
		logic res_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic is_read;
		logic mask_full;
		logic at_end;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/core/bmrsc_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module bmrsc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 512,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bmrsc_ctrl.sv =====
// Controller state machine that sequences clearing, byte walks and result hand-off.
`timescale 1ns / 1ps
module bmrsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bmrsc_pkg::stat_t    stat,
	output bmrsc_pkg::cmd_t     cmd
);

	bmrsc_pkg::state_t state_q;
	bmrsc_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmrsc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmrsc_pkg::ST_CLEAR: begin
				if (stat.clr_last) state_d = bmrsc_pkg::ST_IDLE;
			end
			bmrsc_pkg::ST_IDLE: begin
				if (in_valid) state_d = bmrsc_pkg::ST_WALK;
			end
			bmrsc_pkg::ST_WALK: begin
				if (stat.bad) begin
					state_d = bmrsc_pkg::ST_DONE;
				end else if (stat.is_read || !stat.mask_full) begin
					state_d = bmrsc_pkg::ST_RDWAIT;
				end else if (stat.at_end) begin
					state_d = bmrsc_pkg::ST_DONE;
				end
			end
			bmrsc_pkg::ST_RDWAIT: begin
				if (stat.is_read || stat.at_end) begin
					state_d = bmrsc_pkg::ST_DONE;
				end else begin
					state_d = bmrsc_pkg::ST_WALK;
				end
			end
			bmrsc_pkg::ST_DONE: begin
				if (stat.out_free) state_d = bmrsc_pkg::ST_IDLE;
			end
			default: state_d = bmrsc_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			bmrsc_pkg::ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
			end
			bmrsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			bmrsc_pkg::ST_WALK: begin
				if (!stat.bad) begin
					if (stat.is_read || !stat.mask_full) begin
						cmd.rd_en = 1'b1;
					end else begin
						cmd.wr_full = 1'b1;
						cmd.step    = !stat.at_end;
					end
				end
			end
			bmrsc_pkg::ST_RDWAIT: begin
				if (stat.is_read) begin
					cmd.take_rd = 1'b1;
				end else begin
					cmd.wr_part = 1'b1;
					cmd.step    = !stat.at_end;
				end
			end
			bmrsc_pkg::ST_DONE: begin
				cmd.res_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/core/bmrsc_dp.sv =====
// Datapath with request registers, byte walker, edge masks, bitmap store and result register.
`timescale 1ns / 1ps
module bmrsc_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [bmrsc_pkg::REQ_W-1:0]          req_type,
	input  logic [bmrsc_pkg::INDEX_W-1:0]        range_start,
	input  logic [bmrsc_pkg::INDEX_W-1:0]        range_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bmrsc_pkg::DATA_W-1:0]         read_data,
	output logic                                 status,
	input  bmrsc_pkg::cmd_t                      cmd,
	output bmrsc_pkg::stat_t                     stat
);

	logic [bmrsc_pkg::REQ_W-1:0]  req_q;
	logic                         bad_q;
	logic [bmrsc_pkg::ADDR_W-1:0] start_q;
	logic [bmrsc_pkg::ADDR_W-1:0] end_q;
	logic [bmrsc_pkg::ADDR_W-1:0] cur_q;
	logic [2:0]                   lo_q;
	logic [2:0]                   hi_q;
	logic [bmrsc_pkg::ADDR_W-1:0] clr_q;
	logic [bmrsc_pkg::DATA_W-1:0] res_data_q;
	logic                         out_valid_q;
	logic [bmrsc_pkg::DATA_W-1:0] read_data_q;
	logic                         status_q;

	logic                         bad_in;
	logic [2:0]                   lo;
	logic [2:0]                   hi;
	logic [bmrsc_pkg::DATA_W-1:0] mask;
	logic [bmrsc_pkg::DATA_W-1:0] rdata;
	logic [bmrsc_pkg::DATA_W-1:0] wdata;
	logic [bmrsc_pkg::ADDR_W-1:0] addr;
	logic                         we;

	// Rejection check on the incoming transaction.
	always_comb begin
		case (req_type)
			bmrsc_pkg::REQ_READ: begin
				bad_in = 32'(range_start) >= bmrsc_pkg::MAP_BITS;
			end
			bmrsc_pkg::REQ_SET, bmrsc_pkg::REQ_CLEAR: begin
				bad_in = (range_start > range_end) ||
					(32'(range_end) >= bmrsc_pkg::MAP_BITS);
			end
			default: bad_in = 1'b1;
		endcase
	end

	// Request registers and byte walker.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			bad_q   <= bad_in;
			start_q <= bmrsc_pkg::ADDR_W'(range_start >> 3);
			end_q   <= bmrsc_pkg::ADDR_W'(range_end >> 3);
			cur_q   <= bmrsc_pkg::ADDR_W'(range_start >> 3);
			lo_q    <= range_start[2:0];
			hi_q    <= range_end[2:0];
		end else if (cmd.step) begin
			cur_q <= cur_q + 1'b1;
		end
	end

	// Pending result: zero data unless a read captures the store byte.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_data_q <= bmrsc_pkg::BYTE_ZEROS;
		end else if (cmd.take_rd) begin
			res_data_q <= rdata;
		end
	end

	// Clearing pass counter after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Edge masks for the first and last byte of the range.
	always_comb begin
		lo   = (cur_q == start_q) ? lo_q : 3'd0;
		hi   = (cur_q == end_q) ? hi_q : bmrsc_pkg::BIT_TOP;
		mask = (bmrsc_pkg::BYTE_ONES << lo) & (bmrsc_pkg::BYTE_ONES >> (bmrsc_pkg::BIT_TOP - hi));
	end

	// Store write data and address selection.
	always_comb begin
		addr  = cmd.clr_wr ? clr_q : cur_q;
		we    = cmd.clr_wr | cmd.wr_full | cmd.wr_part;
		wdata = bmrsc_pkg::BYTE_ZEROS;
		if (cmd.wr_full) begin
			wdata = (req_q == bmrsc_pkg::REQ_SET) ? bmrsc_pkg::BYTE_ONES
				: bmrsc_pkg::BYTE_ZEROS;
		end else if (cmd.wr_part) begin
			wdata = (req_q == bmrsc_pkg::REQ_SET) ? (rdata | mask) : (rdata & ~mask);
		end
	end

	bmrsc_ram #(
		.WIDTH (bmrsc_pkg::DATA_W),
		.DEPTH (bmrsc_pkg::MAP_BYTES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	// Output register holding the finished transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			read_data_q <= res_data_q;
			status_q    <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign status    = status_q;

	// Status toward the controller.
	always_comb begin
		stat.bad       = bad_q;
		stat.is_read   = (req_q == bmrsc_pkg::REQ_READ);
		stat.mask_full = (mask == bmrsc_pkg::BYTE_ONES);
		stat.at_end    = (cur_q == end_q);
		stat.clr_last  = (clr_q == bmrsc_pkg::ADDR_W'(bmrsc_pkg::MAP_BYTES - 1));
		stat.out_free  = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/core/bitmap_range_set_clear.sv =====
// Top level: bitmap range set/clear/read engine built from a controller and a datapath.
// Sequence: a rejected request goes from the walk state straight to the done state; a read
// fetches its byte and captures it in the wait state; a set or clear writes whole bytes
// directly and reads, then writes back, partial edge bytes, one store access at a time.
// Throughput: one transaction at a time; the next is accepted in the cycle after the result
// moves into the output register, which waits while an earlier result is still unaccepted.
// Reset: after arst_n rises a clearing pass writes zero to all 512 store bytes, one per cycle.
`timescale 1ns / 1ps
module bitmap_range_set_clear (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bmrsc_pkg::REQ_W-1:0]   req_type,
	input  logic [bmrsc_pkg::INDEX_W-1:0] range_start,
	input  logic [bmrsc_pkg::INDEX_W-1:0] range_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bmrsc_pkg::DATA_W-1:0]  read_data,
	output logic                          status
);

	bmrsc_pkg::cmd_t  cmd;
	bmrsc_pkg::stat_t stat;

	bmrsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmrsc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.range_start (range_start),
		.range_end   (range_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.status      (status),
		.cmd         (cmd),
		.stat        (stat)
	);

endmodule

// ===== rtl/core/bmrsc_checker.sv =====
// Port-level checker for the bitmap range block, bound to the top level.
`timescale 1ns / 1ps
module bmrsc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [bmrsc_pkg::REQ_W-1:0]   req_type,
	input logic [bmrsc_pkg::INDEX_W-1:0] range_start,
	input logic [bmrsc_pkg::INDEX_W-1:0] range_end,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [bmrsc_pkg::DATA_W-1:0]  read_data,
	input logic                          status
);

	// A stalled result stays valid and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
		else $error("result changed while stalled");

	// A rejected transaction never carries store data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> read_data == bmrsc_pkg::BYTE_ZEROS)
		else $error("rejected result carries data");

	// Only one transaction is in flight; the input closes right after an acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted while one is in flight");

	// A result never appears in the cycle right after acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind bitmap_range_set_clear bmrsc_checker u_bmrsc_checker (.*);
